// ===== design/two_item_packet_deframer_macros.svh =====
// Assertion macros used by the deframer checker.
`ifndef TWO_ITEM_PACKET_DEFRAMER_MACROS_SVH
`define TWO_ITEM_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, off during reset.
`define TIPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tipd: same-cycle check failed");

// Next-cycle implication, off during reset.
`define TIPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tipd: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define TIPD_ASSERT_ALWAYS_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("tipd: reset check failed");

`endif

// ===== design/tipd_pkg.sv =====
// Types, codes and constants of the two-item packet deframer.
package tipd_pkg;

    localparam int CapWidth     = 13;
    localparam int HeaderBytes  = 12;
    localparam int LenBytes     = 4;
    localparam int QDepth       = 3;
    localparam logic [CapWidth-1:0] MaxItemBytes = 13'd4096;
    localparam logic [CapWidth-1:0] CapReset     = 13'd4096;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_ITEM1   = 3'd1,
        PH_LEN2    = 3'd2,
        PH_ITEM2   = 3'd3,
        PH_DONE    = 3'd4,
        PH_SWALLOW = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_ITEM1   = 2'd0,
        KIND_ITEM2   = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SHORT       = 3'd1;
    localparam logic [2:0] ST_FIRST_LONG  = 3'd2;
    localparam logic [2:0] ST_SECOND_LONG = 3'd3;
    localparam logic [2:0] ST_COUNT_OVER  = 3'd4;
    localparam logic [2:0] ST_ZERO_CAP    = 3'd5;

    localparam logic CFG_FIRST_CAP  = 1'b0;
    localparam logic CFG_SECOND_CAP = 1'b1;

    typedef struct packed {
        t_kind                kind;
        logic [7:0]           data_byte;
        logic signed [31:0]   command;
        logic signed [31:0]   item_count;
        logic [CapWidth-1:0]  first_length;
        logic [CapWidth-1:0]  second_length;
        logic [2:0]           status;
        logic                 last_of_run;
    } t_result;

    function automatic logic [CapWidth-1:0] eff_cap(input logic [CapWidth-1:0] c);
        return (c > MaxItemBytes) ? MaxItemBytes : c;
    endfunction

    // signed count strictly above k (k non-negative)
    function automatic logic count_above(input logic [31:0] c, input logic [31:0] k);
        return !c[31] && (c > k);
    endfunction

endpackage

// ===== design/tipd_byte_if.sv =====
// Input channel: one packet byte per request.
interface tipd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_packet;

    modport source (output valid, output byte_value, output end_of_packet, input ready);
    modport sink (input valid, input byte_value, input end_of_packet, output ready);
endinterface

// ===== design/tipd_result_if.sv =====
// Output channel: one data byte or packet summary per request.
interface tipd_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         data_byte;
    logic signed [31:0] command;
    logic signed [31:0] item_count;
    logic [12:0]        first_length;
    logic [12:0]        second_length;
    logic [2:0]         status;
    logic               last_of_run;

    modport source (
        output valid, output kind, output data_byte, output command, output item_count,
        output first_length, output second_length, output status, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input command, input item_count,
        input first_length, input second_length, input status, input last_of_run,
        output ready
    );
endinterface

// ===== design/two_item_packet_deframer.sv =====
// Top level of the two-item packet deframer.
// One packet byte is accepted per cycle while ready, and its header/length/item state is
// updated in that same cycle; its results (at most a data byte and a summary) go into a
// three-entry result queue that drives the output channel one request per cycle while the
// sink is ready. Input ready is high while that queue holds at most one entry, so bytes
// flow at one per cycle as long as the sink keeps up; an end-flagged data byte produces
// two results (the byte and the summary) and holds the input while the queue drains.
module two_item_packet_deframer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [12:0]   i_cfg_data,
    tipd_byte_if.sink     i_byte,
    tipd_result_if.source o_result
);

    logic [12:0] r_cap1, r_cap2, cap1, cap2;

    tipd_pkg::t_phase r_phase, s_phase, n_phase;
    logic [12:0] r_cnt, s_cnt, n_cnt;
    logic [31:0] r_cmd, s_cmd, n_cmd;
    logic [31:0] r_count, s_count, n_count;
    logic [31:0] r_len, s_len, n_len;
    logic [12:0] r_len1, s_len1, n_len1;
    logic [12:0] r_len2, s_len2, n_len2;
    logic [2:0]  r_err, s_err, n_err;

    logic            accept, eop, emit_data, cmd_ok, cnt_ok, pop;
    logic [7:0]      b;
    logic [2:0]      sum_status;
    logic [1:0]      nw, base, r_qcnt, n_qcnt;
    tipd_pkg::t_kind data_kind;
    tipd_pkg::t_result w_data, w_sum, w0;
    tipd_pkg::t_result r_q [tipd_pkg::QDepth];
    tipd_pkg::t_result n_q [tipd_pkg::QDepth];

    assign b      = i_byte.byte_value;
    assign eop    = i_byte.end_of_packet;
    assign i_byte.ready = (r_qcnt <= 2'd1);
    assign accept = i_byte.valid && i_byte.ready;
    assign cap1   = tipd_pkg::eff_cap(r_cap1);
    assign cap2   = tipd_pkg::eff_cap(r_cap2);

    // per-byte state step
    always_comb begin
        s_phase   = r_phase;
        s_cnt     = r_cnt;
        s_cmd     = r_cmd;
        s_count   = r_count;
        s_len     = r_len;
        s_len1    = r_len1;
        s_len2    = r_len2;
        s_err     = r_err;
        emit_data = 1'b0;
        data_kind = tipd_pkg::KIND_ITEM1;
        case (r_phase)
            tipd_pkg::PH_HEADER: begin
                if (r_cnt == '0 && (cap1 == '0 || cap2 == '0)) begin
                    s_err   = tipd_pkg::ST_ZERO_CAP;
                    s_phase = tipd_pkg::PH_SWALLOW;
                end else begin
                    if (r_cnt < 13'd4) begin
                        s_cmd = {r_cmd[23:0], b};
                    end else if (r_cnt < 13'd8) begin
                        s_count = {r_count[23:0], b};
                    end else begin
                        s_len = {r_len[23:0], b};
                    end
                    s_cnt = r_cnt + 13'd1;
                    if (r_cnt == 13'(tipd_pkg::HeaderBytes - 1)) begin
                        s_cnt = '0;
                        if (!tipd_pkg::count_above(r_count, 32'd0)) begin
                            s_phase = tipd_pkg::PH_DONE;
                        end else if (s_len > {19'd0, cap1}) begin
                            s_err   = tipd_pkg::ST_FIRST_LONG;
                            s_phase = tipd_pkg::PH_SWALLOW;
                        end else if (s_len == '0) begin
                            s_len1  = '0;
                            s_phase = tipd_pkg::count_above(r_count, 32'd1) ?
                                      tipd_pkg::PH_LEN2 : tipd_pkg::PH_DONE;
                        end else begin
                            s_phase = tipd_pkg::PH_ITEM1;
                        end
                    end
                end
            end
            tipd_pkg::PH_ITEM1: begin
                emit_data = 1'b1;
                s_cnt     = r_cnt + 13'd1;
                if (s_cnt >= r_len[12:0]) begin
                    s_len1  = r_len[12:0];
                    s_cnt   = '0;
                    s_phase = tipd_pkg::count_above(r_count, 32'd1) ?
                              tipd_pkg::PH_LEN2 : tipd_pkg::PH_DONE;
                end
            end
            tipd_pkg::PH_LEN2: begin
                s_len = {r_len[23:0], b};
                s_cnt = r_cnt + 13'd1;
                if (r_cnt == 13'(tipd_pkg::LenBytes - 1)) begin
                    s_cnt = '0;
                    if (s_len > {19'd0, cap2}) begin
                        s_err   = tipd_pkg::ST_SECOND_LONG;
                        s_phase = tipd_pkg::PH_SWALLOW;
                    end else if (s_len == '0) begin
                        s_len2  = '0;
                        s_phase = tipd_pkg::PH_DONE;
                    end else begin
                        s_phase = tipd_pkg::PH_ITEM2;
                    end
                end
            end
            tipd_pkg::PH_ITEM2: begin
                emit_data = 1'b1;
                data_kind = tipd_pkg::KIND_ITEM2;
                s_cnt     = r_cnt + 13'd1;
                if (s_cnt >= r_len[12:0]) begin
                    s_len2  = r_len[12:0];
                    s_cnt   = '0;
                    s_phase = tipd_pkg::PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    // end of packet clears the packet state for the next one
    always_comb begin
        if (eop) begin
            n_phase = tipd_pkg::PH_HEADER;
            n_cnt   = '0;
            n_cmd   = '0;
            n_count = '0;
            n_len   = '0;
            n_len1  = '0;
            n_len2  = '0;
            n_err   = '0;
        end else begin
            n_phase = s_phase;
            n_cnt   = s_cnt;
            n_cmd   = s_cmd;
            n_count = s_count;
            n_len   = s_len;
            n_len1  = s_len1;
            n_len2  = s_len2;
            n_err   = s_err;
        end
    end

    // results of this byte
    always_comb begin
        if (s_err != '0) begin
            sum_status = s_err;
        end else if (s_phase == tipd_pkg::PH_DONE) begin
            sum_status = tipd_pkg::count_above(s_count, 32'd2) ?
                         tipd_pkg::ST_COUNT_OVER : tipd_pkg::ST_OK;
        end else begin
            sum_status = tipd_pkg::ST_SHORT;
        end

        if (s_err == tipd_pkg::ST_ZERO_CAP) begin
            cmd_ok = 1'b0;
            cnt_ok = 1'b0;
        end else if (s_phase == tipd_pkg::PH_HEADER) begin
            cmd_ok = (s_cnt >= 13'd4);
            cnt_ok = (s_cnt >= 13'd8);
        end else begin
            cmd_ok = 1'b1;
            cnt_ok = 1'b1;
        end

        w_data             = '0;
        w_data.kind        = data_kind;
        w_data.data_byte   = b;
        w_data.last_of_run = !eop;

        w_sum               = '0;
        w_sum.kind          = tipd_pkg::KIND_SUMMARY;
        w_sum.command       = cmd_ok ? s_cmd : '0;
        w_sum.item_count    = cnt_ok ? s_count : '0;
        w_sum.first_length  = s_len1;
        w_sum.second_length = s_len2;
        w_sum.status        = sum_status;
        w_sum.last_of_run   = 1'b1;

        nw = {1'b0, emit_data} + {1'b0, eop};
        w0 = emit_data ? w_data : w_sum;
    end

    // result queue, head at entry 0
    always_comb begin
        pop    = (r_qcnt != '0) && o_result.ready;
        base   = r_qcnt - {1'b0, pop};
        n_qcnt = base + (accept ? nw : 2'd0);
        for (int i = 0; i < tipd_pkg::QDepth; i++) begin
            n_q[i] = pop ? r_q[(i < tipd_pkg::QDepth - 1) ? i + 1 : i] : r_q[i];
            if (accept && nw != '0 && 2'(i) == base) begin
                n_q[i] = w0;
            end
            if (accept && nw == 2'd2 && 2'(i) == base + 2'd1) begin
                n_q[i] = w_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap1  <= tipd_pkg::CapReset;
            r_cap2  <= tipd_pkg::CapReset;
            r_phase <= tipd_pkg::PH_HEADER;
            r_cnt   <= '0;
            r_cmd   <= '0;
            r_count <= '0;
            r_len   <= '0;
            r_len1  <= '0;
            r_len2  <= '0;
            r_err   <= '0;
            r_qcnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tipd_pkg::CFG_FIRST_CAP:  r_cap1 <= i_cfg_data;
                    tipd_pkg::CFG_SECOND_CAP: r_cap2 <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_cmd   <= n_cmd;
                r_count <= n_count;
                r_len   <= n_len;
                r_len1  <= n_len1;
                r_len2  <= n_len2;
                r_err   <= n_err;
            end
            r_qcnt <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_result.valid         = (r_qcnt != '0);
    assign o_result.kind          = r_q[0].kind;
    assign o_result.data_byte     = r_q[0].data_byte;
    assign o_result.command       = r_q[0].command;
    assign o_result.item_count    = r_q[0].item_count;
    assign o_result.first_length  = r_q[0].first_length;
    assign o_result.second_length = r_q[0].second_length;
    assign o_result.status        = r_q[0].status;
    assign o_result.last_of_run   = r_q[0].last_of_run;

endmodule

// ===== design/tipd_checker.sv =====
// Port-level checks of the deframer, bound to the top level.
`include "two_item_packet_deframer_macros.svh"

module tipd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         i_kind,
    input logic signed [31:0] i_command,
    input logic signed [31:0] i_item_count,
    input logic [12:0]        i_first_length,
    input logic [12:0]        i_second_length,
    input logic [2:0]         i_status,
    input logic               i_last_of_run
);

    `TIPD_ASSERT_ALWAYS_NEXT(a_reset_empty, !i_rst_n, !i_out_valid)

    `TIPD_ASSERT_NOW(a_data_fields_clear, i_out_valid && (i_kind != tipd_pkg::KIND_SUMMARY), (i_command == '0) && (i_item_count == '0) && (i_first_length == '0) && (i_second_length == '0) && (i_status == '0))

    `TIPD_ASSERT_NOW(a_summary_closes_run, i_out_valid && (i_kind == tipd_pkg::KIND_SUMMARY), i_last_of_run && (i_status <= tipd_pkg::ST_ZERO_CAP))

    `TIPD_ASSERT_NEXT(a_summary_follows, i_out_valid && i_out_ready && (i_kind != tipd_pkg::KIND_SUMMARY) && !i_last_of_run, i_out_valid && (i_kind == tipd_pkg::KIND_SUMMARY))

endmodule

bind two_item_packet_deframer tipd_checker u_tipd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_kind          (o_result.kind),
    .i_command       (o_result.command),
    .i_item_count    (o_result.item_count),
    .i_first_length  (o_result.first_length),
    .i_second_length (o_result.second_length),
    .i_status        (o_result.status),
    .i_last_of_run   (o_result.last_of_run)
);
